FILE: rtl/lmpp_pkg.sv
`timescale 1ns / 1ps
package lmpp_pkg;

   // fixed field widths
   localparam int X_W      = 6;
   localparam int Y_W      = 4;
   localparam int COLOUR_W = 2;
   localparam int CHIP_W   = 4;
   localparam int ADDR_W   = 6;
   localparam int NIBBLE_W = 4;
   localparam int NDISP_W  = 2;

   // one chip: 64 words, green plane 0..31, red plane 32..63
   localparam int WORDS_PER_CHIP = 64;
   localparam int PLANE_WORDS    = WORDS_PER_CHIP / 2;
   localparam int WADDR_W        = $clog2(PLANE_WORDS);
   localparam int CIDX_W         = 3;

   localparam logic [NDISP_W-1:0] NDISP_RESET = 2'd1;

   // classified plot request, chip numbered from zero
   typedef struct packed {
      logic [CIDX_W-1:0]   chip_idx;
      logic [WADDR_W-1:0]  word_addr;
      logic [1:0]          bit_sel;
      logic [COLOUR_W-1:0] colour;
   } plot_entry_type;

   typedef struct packed {
      logic           valid;
      plot_entry_type entry;
   } plot_slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SEND_G,
      ST_SEND_R
   } back_state_type;

endpackage

FILE: rtl/lmpp_if.sv
`timescale 1ns / 1ps
interface lmpp_req_if;
   logic                             valid;
   logic                             ready;
   logic [lmpp_pkg::X_W-1:0]         pixel_x;
   logic [lmpp_pkg::Y_W-1:0]         pixel_y;
   logic [lmpp_pkg::COLOUR_W-1:0]    colour;

   modport source (output valid, output pixel_x, output pixel_y, output colour, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input colour, output ready);
endinterface

interface lmpp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lmpp_pkg::CHIP_W-1:0]      chip_number;
   logic [lmpp_pkg::ADDR_W-1:0]      word_address;
   logic [lmpp_pkg::NIBBLE_W-1:0]    nibble;
   logic                             last_write;

   modport source (output valid, output chip_number, output word_address, output nibble,
                   output last_write, input ready);
   modport sink   (input valid, input chip_number, input word_address, input nibble,
                   input last_write, output ready);
endinterface

interface lmpp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lmpp_pkg::NDISP_W-1:0]     num_displays;

   modport source (output valid, output num_displays, input ready);
   modport sink   (input valid, input num_displays, output ready);
endinterface

FILE: rtl/lmpp_ram.sv
`timescale 1ns / 1ps
module lmpp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/lmpp_front.sv
`timescale 1ns / 1ps
module lmpp_front #(
   parameter int MAX_CHIPS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   lmpp_req_if.sink                req_bus,
   lmpp_csr_if.sink                csr_bus,
   input  logic                    clearing,
   input  logic                    q_full,
   output lmpp_pkg::plot_slot_type push
);

   localparam logic [lmpp_pkg::CIDX_W:0] CHIP_LIMIT = (lmpp_pkg::CIDX_W + 1)'(MAX_CHIPS);

   logic [lmpp_pkg::NDISP_W-1:0] ndisp_ff, ndisp_in;
   logic [lmpp_pkg::CIDX_W-1:0]  chip_idx;
   logic                         col_ok, chip_ok, accept;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_full && !clearing;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      ndisp_in = ndisp_ff;
      if (csr_bus.valid) begin
         ndisp_in = csr_bus.num_displays;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndisp_ff <= lmpp_pkg::NDISP_RESET;
      end else begin
         ndisp_ff <= ndisp_in;
      end
   end

   // chip - 1 = 4*board + 2*lower half + right half of board
   assign chip_idx = {req_bus.pixel_x[5], req_bus.pixel_y[3], req_bus.pixel_x[4]};
   assign col_ok   = {1'b0, req_bus.pixel_x[5]} < ndisp_ff;
   assign chip_ok  = {1'b0, chip_idx} < CHIP_LIMIT;

   always_comb begin
      push.valid           = accept && col_ok && chip_ok;
      push.entry.chip_idx  = chip_idx;
      push.entry.word_addr = {req_bus.pixel_x[3:0], req_bus.pixel_y[2]};
      push.entry.bit_sel   = req_bus.pixel_y[1:0];
      push.entry.colour    = req_bus.colour;
   end

endmodule

FILE: rtl/lmpp_queue.sv
`timescale 1ns / 1ps
module lmpp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  lmpp_pkg::plot_slot_type push,
   output logic                    full,
   output lmpp_pkg::plot_slot_type head,
   input  logic                    pop
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lmpp_pkg::plot_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: rtl/lmpp_back.sv
`timescale 1ns / 1ps
module lmpp_back #(
   parameter int MAX_CHIPS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lmpp_pkg::plot_slot_type head,
   output logic                    pop,
   output logic                    clearing,
   lmpp_rsp_if.source              rsp_bus
);

   localparam int PLANE_DEPTH = MAX_CHIPS * lmpp_pkg::PLANE_WORDS;
   localparam int RAM_AW      = $clog2(PLANE_DEPTH);
   localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(PLANE_DEPTH - 1);

   lmpp_pkg::back_state_type state_ff, state_in;
   lmpp_pkg::plot_entry_type ent_ff, ent_in;
   logic [RAM_AW-1:0]             clr_ff, clr_in;
   logic [lmpp_pkg::NIBBLE_W-1:0] gnib_ff, gnib_in, rnib_ff, rnib_in;

   logic                          ram_we;
   logic [RAM_AW-1:0]             ram_waddr, ram_raddr;
   logic [lmpp_pkg::NIBBLE_W-1:0] g_wdata, r_wdata, g_rd, r_rd;
   logic [lmpp_pkg::NIBBLE_W-1:0] mask, g_new, r_new;
   logic [1:0]                    cur;
   logic                          changed;

   lmpp_ram #(.WIDTH(lmpp_pkg::NIBBLE_W), .DEPTH(PLANE_DEPTH)) u_green (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (g_wdata),
      .raddr (ram_raddr),
      .rdata (g_rd)
   );

   lmpp_ram #(.WIDTH(lmpp_pkg::NIBBLE_W), .DEPTH(PLANE_DEPTH)) u_red (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (r_wdata),
      .raddr (ram_raddr),
      .rdata (r_rd)
   );

   // read-modify-write on the looked-up pair
   assign mask    = 4'b1000 >> ent_ff.bit_sel;
   assign cur     = {|(r_rd & mask), |(g_rd & mask)};
   assign changed = cur != ent_ff.colour;
   assign g_new   = ent_ff.colour[0] ? (g_rd | mask) : (g_rd & ~mask);
   assign r_new   = ent_ff.colour[1] ? (r_rd | mask) : (r_rd & ~mask);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmpp_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = lmpp_pkg::ST_IDLE;
            end
         end
         lmpp_pkg::ST_IDLE: begin
            if (head.valid) begin
               state_in = lmpp_pkg::ST_LOOK;
            end
         end
         lmpp_pkg::ST_LOOK: begin
            state_in = changed ? lmpp_pkg::ST_SEND_G : lmpp_pkg::ST_IDLE;
         end
         lmpp_pkg::ST_SEND_G: begin
            if (rsp_bus.ready) begin
               state_in = lmpp_pkg::ST_SEND_R;
            end
         end
         lmpp_pkg::ST_SEND_R: begin
            if (rsp_bus.ready) begin
               state_in = lmpp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lmpp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      clearing  = state_ff == lmpp_pkg::ST_CLEAR;
      pop       = (state_ff == lmpp_pkg::ST_IDLE) && head.valid;
      ram_raddr = RAM_AW'({head.entry.chip_idx, head.entry.word_addr});
      ent_in    = pop ? head.entry : ent_ff;
      clr_in    = clearing ? clr_ff + RAM_AW'(1) : clr_ff;
      ram_we    = 1'b0;
      ram_waddr = RAM_AW'({ent_ff.chip_idx, ent_ff.word_addr});
      g_wdata   = g_new;
      r_wdata   = r_new;
      gnib_in   = gnib_ff;
      rnib_in   = rnib_ff;
      if (clearing) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         g_wdata   = '0;
         r_wdata   = '0;
      end else if ((state_ff == lmpp_pkg::ST_LOOK) && changed) begin
         ram_we  = 1'b1;
         gnib_in = g_new;
         rnib_in = r_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmpp_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      gnib_ff <= gnib_in;
      rnib_ff <= rnib_in;
   end

   assign rsp_bus.valid        = (state_ff == lmpp_pkg::ST_SEND_G) ||
                                 (state_ff == lmpp_pkg::ST_SEND_R);
   assign rsp_bus.last_write   = state_ff == lmpp_pkg::ST_SEND_R;
   assign rsp_bus.chip_number  = lmpp_pkg::CHIP_W'(ent_ff.chip_idx) + lmpp_pkg::CHIP_W'(1);
   assign rsp_bus.word_address = {rsp_bus.last_write, ent_ff.word_addr};
   assign rsp_bus.nibble       = rsp_bus.last_write ? rnib_ff : gnib_ff;

endmodule

FILE: rtl/led_matrix_pixel_plotter.sv
`timescale 1ns / 1ps
// channel   dir  handshake        payload
// req_bus   in   valid / ready    pixel_x[5:0] pixel_y[3:0] colour[1:0]
// rsp_bus   out  valid / ready    chip_number[3:0] word_address[5:0] nibble[3:0] last_write
// csr_bus   in   valid / ready    num_displays[1:0] (ready always high)
//
// Back end: a plot that changes the pixel passes pop + shadow read, compare + write, green
//   write out, red write out (each held until rsp_bus.ready); one that changes nothing
//   ends at the compare; one off the matrix is never queued. Shadow reads are registered.
// Reset: synchronous; afterwards the shadow RAMs are zeroed, one word per cycle, all
//   MAX_CHIPS*32 words of each (256 at the default), with req_bus.ready low.
// Stalls: a 2-entry queue between front and back keeps req_bus moving while rsp_bus
//   is held off; the front stalls only when the queue is full or the shadow is clearing.
module led_matrix_pixel_plotter #(
   parameter int MAX_CHIPS = 8
) (
   input  logic        clock,
   input  logic        reset,
   lmpp_req_if.sink    req_bus,
   lmpp_rsp_if.source  rsp_bus,
   lmpp_csr_if.sink    csr_bus
);

   lmpp_pkg::plot_slot_type push;   // classified request into the queue
   lmpp_pkg::plot_slot_type head;   // oldest queued request
   logic                    q_full;
   logic                    pop;
   logic                    clearing;

   // front: csr register, bounds check, chip / address / bit decode
   lmpp_front #(.MAX_CHIPS(MAX_CHIPS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .clearing (clearing),
      .q_full   (q_full),
      .push     (push)
   );

   lmpp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // back: shadow read-modify-write, emits the green/red write pair
   lmpp_back #(.MAX_CHIPS(MAX_CHIPS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .clearing (clearing),
      .rsp_bus  (rsp_bus)
   );

   // no write leaves while the shadow is being zeroed
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_bus.valid && !pop)
      else $error("response or pop during shadow clear");

   // a green write is always followed by the red write of the same chip
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_write |=>
         rsp_bus.valid && rsp_bus.last_write && $stable(rsp_bus.chip_number))
      else $error("red write does not follow green write");

   // back end only pops a queue that holds something
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

FILE: dv/lmpp_plot_checker.sv
`timescale 1ns / 1ps
module lmpp_plot_checker #(
   parameter int MAX_CHIPS = 8
) (
   input  logic clock,
   input  logic reset,
   lmpp_req_if  req_bus,
   lmpp_rsp_if  rsp_bus,
   lmpp_csr_if  csr_bus,
   output int   fail_count,
   output int   outstanding
);

   localparam int SHADOW_DEPTH = MAX_CHIPS * lmpp_pkg::WORDS_PER_CHIP;

   typedef struct packed {
      logic [lmpp_pkg::CHIP_W-1:0]   chip;
      logic [lmpp_pkg::ADDR_W-1:0]   addr;
      logic [lmpp_pkg::NIBBLE_W-1:0] nibble;
      logic                          last;
   } word_write_type;

   logic [lmpp_pkg::NIBBLE_W-1:0] shadow [SHADOW_DEPTH];
   logic [lmpp_pkg::NDISP_W-1:0]  boards;
   word_write_type                queued_writes [$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   // shadow read-modify-write; queues the green then red word write
   function automatic void predict_plot(input logic [lmpp_pkg::X_W-1:0] px,
                                        input logic [lmpp_pkg::Y_W-1:0] py,
                                        input logic [lmpp_pkg::COLOUR_W-1:0] pc);
      int unsigned                   chip;
      int unsigned                   addr;
      int unsigned                   gidx;
      int unsigned                   ridx;
      logic [lmpp_pkg::NIBBLE_W-1:0] mask;
      logic [lmpp_pkg::NIBBLE_W-1:0] gw;
      logic [lmpp_pkg::NIBBLE_W-1:0] rw;
      logic [lmpp_pkg::COLOUR_W-1:0] cur;
      word_write_type                wr;
      if (int'(px) >= 32 * int'(boards)) return;
      chip = 1 + 4 * (int'(px) / 32) + (int'(px) % 32) / 16 + (int'(py) > 7 ? 2 : 0);
      if (chip > MAX_CHIPS) return;
      addr = (int'(px) % 16) * 2 + (int'(py) % 8) / 4;
      mask = 4'b1000 >> py[1:0];
      gidx = (chip - 1) * lmpp_pkg::WORDS_PER_CHIP + addr;
      ridx = gidx + lmpp_pkg::PLANE_WORDS;
      if (ridx >= SHADOW_DEPTH) return;
      gw  = shadow[gidx];
      rw  = shadow[ridx];
      cur = {(rw & mask) != 0, (gw & mask) != 0};
      if (cur == pc) return;
      gw = pc[0] ? (gw | mask) : (gw & ~mask);
      rw = pc[1] ? (rw | mask) : (rw & ~mask);
      shadow[gidx] = gw;
      shadow[ridx] = rw;
      wr.chip   = lmpp_pkg::CHIP_W'(chip);
      wr.addr   = lmpp_pkg::ADDR_W'(addr);
      wr.nibble = gw;
      wr.last   = 1'b0;
      queued_writes.push_back(wr);
      wr.addr   = lmpp_pkg::ADDR_W'(addr + lmpp_pkg::PLANE_WORDS);
      wr.nibble = rw;
      wr.last   = 1'b1;
      queued_writes.push_back(wr);
   endfunction

   always @(posedge clock) begin
      word_write_type want;
      if (reset) begin
         foreach (shadow[i]) shadow[i] = '0;
         boards     = lmpp_pkg::NDISP_RESET;
         fail_count = 0;
         queued_writes.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (queued_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write chip %0d addr %0d nibble %0h last %0b",
                  rsp_bus.chip_number, rsp_bus.word_address, rsp_bus.nibble,
                  rsp_bus.last_write));
            end else begin
               want = queued_writes.pop_front();
               if (rsp_bus.chip_number !== want.chip)
                  report_mismatch($sformatf("chip_number got %0d want %0d",
                     rsp_bus.chip_number, want.chip));
               if (rsp_bus.word_address !== want.addr)
                  report_mismatch($sformatf("word_address got %0d want %0d",
                     rsp_bus.word_address, want.addr));
               if (rsp_bus.nibble !== want.nibble)
                  report_mismatch($sformatf("nibble got %0h want %0h",
                     rsp_bus.nibble, want.nibble));
               if (rsp_bus.last_write !== want.last)
                  report_mismatch($sformatf("last_write got %0b want %0b",
                     rsp_bus.last_write, want.last));
            end
         end
         if (csr_bus.valid && csr_bus.ready)
            boards = csr_bus.num_displays;
         if (req_bus.valid && req_bus.ready)
            predict_plot(req_bus.pixel_x, req_bus.pixel_y, req_bus.colour);
      end
      outstanding <= queued_writes.size();
   end

endmodule

FILE: dv/tb_led_matrix_pixel_plotter.sv
`timescale 1ns / 1ps
module tb_led_matrix_pixel_plotter;

   localparam int PLOT_MAX_CHIPS = 8;
   // queue of two plus the back end's look and write-out states; margin on top
   localparam int SETTLE_CYCLES  = 16;
   // covers the shadow clear after reset, with headroom
   localparam int STALL_LIMIT    = 3000;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   idle_cycles;
   bit   calm_stretch;   // when set, neither side inserts gaps

   lmpp_req_if req_bus ();
   lmpp_rsp_if rsp_bus ();
   lmpp_csr_if csr_bus ();

   led_matrix_pixel_plotter #(.MAX_CHIPS(PLOT_MAX_CHIPS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lmpp_plot_checker #(.MAX_CHIPS(PLOT_MAX_CHIPS)) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // roughly 23 percent gap chance, off during the calm stretch
   function automatic bit gap_roll();
      return !calm_stretch && ($urandom_range(99) < 23);
   endfunction

   // write-side stalls; changes only on the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && !gap_roll();
   end

   // watchdog: any cycle with no handshake on any channel counts
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the request
   // is taken. valid is never lowered and raised in the same step.
   task automatic plot(input logic [lmpp_pkg::X_W-1:0] x, input logic [lmpp_pkg::Y_W-1:0] y,
                       input logic [lmpp_pkg::COLOUR_W-1:0] c);
      while (gap_roll()) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.pixel_x = x;
      req_bus.pixel_y = y;
      req_bus.colour  = c;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Stop requests, wait for every predicted write, then let the back end
   // finish any plot that produced nothing.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // board count change; only done with the block idle
   task automatic set_boards(input logic [lmpp_pkg::NDISP_W-1:0] n);
      drain();
      csr_bus.valid        = 1'b1;
      csr_bus.num_displays = n;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Random plots at a fixed board count. Most land on a few hot words so the
   // shadow gets revisited: same-colour repeats and shared nibbles. A few
   // go anywhere on the 6-bit range, off the matrix included.
   task automatic random_phase(input logic [lmpp_pkg::NDISP_W-1:0] n, input int count);
      int                          span;
      int                          pick;
      logic [lmpp_pkg::X_W-1:0]    x;
      set_boards(n);
      span = (n == 0) ? 63 : ((32 * n - 1 > 63) ? 63 : 32 * n - 1);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55)
            x = lmpp_pkg::X_W'($urandom_range(0, span / 16) * 16 + $urandom_range(0, 1));
         else if (pick < 90)
            x = lmpp_pkg::X_W'($urandom_range(0, span));
         else
            x = lmpp_pkg::X_W'($urandom_range(0, 63));
         plot(x, lmpp_pkg::Y_W'($urandom_range(0, 15)),
              lmpp_pkg::COLOUR_W'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      calm_stretch         = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.pixel_x      = '0;
      req_bus.pixel_y      = '0;
      req_bus.colour       = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.num_displays = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed, reset board count of one ---
      plot(6'd0,  4'd0,  2'd1);   // first green pixel
      plot(6'd0,  4'd0,  2'd1);   // same colour again: no writes
      plot(6'd0,  4'd1,  2'd2);   // neighbor bit, same word
      plot(6'd0,  4'd0,  2'd3);   // green to orange
      plot(6'd0,  4'd0,  2'd0);   // back to black
      plot(6'd31, 4'd15, 2'd3);   // last chip of the board, far corner
      plot(6'd16, 4'd8,  2'd2);
      plot(6'd15, 4'd7,  2'd1);
      plot(6'd32, 4'd0,  2'd1);   // just past the right edge
      plot(6'd63, 4'd15, 2'd3);   // far off the matrix

      // --- two boards: upper chips reachable ---
      set_boards(2'd2);
      plot(6'd63, 4'd15, 2'd3);   // chip eight, top address
      plot(6'd32, 4'd0,  2'd2);
      plot(6'd48, 4'd7,  2'd1);
      plot(6'd47, 4'd12, 2'd3);
      plot(6'd63, 4'd15, 2'd0);

      // --- zero boards: everything rejected ---
      set_boards(2'd0);
      plot(6'd0,  4'd0,  2'd2);
      plot(6'd63, 4'd15, 2'd1);

      // --- three boards: the whole x range is on the matrix ---
      set_boards(2'd3);
      plot(6'd40, 4'd4,  2'd3);
      plot(6'd40, 4'd4,  2'd3);   // repeat: no writes
      plot(6'd5,  4'd9,  2'd2);

      // --- random ---
      random_phase(2'd2, 180);
      random_phase(2'd1, 110);
      calm_stretch = 1'b1;         // back-to-back on both sides
      random_phase(2'd3, 160);
      calm_stretch = 1'b0;
      random_phase(2'd0, 8);
      random_phase(2'd2, 60);

      drain();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
